// ===== sv/round_robin_run_queue_unit_assert.svh =====
// Assertion macros for the round-robin run queue checker.
`ifndef ROUND_ROBIN_RUN_QUEUE_UNIT_ASSERT_SVH
`define ROUND_ROBIN_RUN_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define RRQ_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rrq: same-cycle check failed");

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define RRQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rrq: next-cycle check failed");

`endif

// ===== sv/rrq_pkg.sv =====
// Shared constants, codes and control/status types for the run queue.
package rrq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_WIDTH_DEF    = 8;

  // Fixed field widths at the ports
  localparam int CMD_W = 2;
  localparam int ENT_W = 8;
  localparam int CNT_W = 5;
  localparam int ST_W  = 2;

  // Commands
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PICK   = 2'd2;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
  localparam logic [ST_W-1:0] ST_NOMATCH = 2'd2;

  // Read offset select (relative to the scan index)
  localparam logic [1:0] RD_IDX  = 2'd0;
  localparam logic [1:0] RD_IDX1 = 2'd1;
  localparam logic [1:0] RD_IDX2 = 2'd2;

  // Write select
  localparam logic [1:0] WR_TAIL_ID = 2'd0;  // tail <= latched id
  localparam logic [1:0] WR_TAIL_RD = 2'd1;  // tail <= read data
  localparam logic [1:0] WR_IDX_RD  = 2'd2;  // scan index <= read data

  typedef struct packed {
    logic             load;
    logic             rd_en;
    logic [1:0]       rd_sel;
    logic             idx_inc;
    logic             wr_en;
    logic [1:0]       wr_sel;
    logic             head_inc;
    logic             cnt_inc;
    logic             cnt_dec;
    logic             emit;
    logic [ST_W-1:0]  emit_status;
    logic             emit_pick;
  } ctl_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             empty;
    logic             full;
    logic             last;   // scan index is the last entry
    logic             last1;  // scan index + 1 is the last entry
    logic             match;  // read data equals latched id
  } stat_t;

endpackage

// ===== sv/round_robin_run_queue_unit.sv =====
// Top level of the round-robin run queue: sequencer plus queue datapath.
//
//  channel   | ports                                      | handshake
//  ----------+--------------------------------------------+-------------------------------
//  command   | in_cmd, in_entity_id                       | taken when start && !busy
//  result    | out_picked_valid, out_picked_id,           | out_valid high for one cycle,
//            | out_queue_count, out_status                | receiver cannot hold it off
//
//  Add, an unused code and a pick or remove on an empty queue finish in S_EXEC;
//  pick then passes through S_PICK; remove scans entries in S_SCAN, then moves
//  each later entry down in S_SHIFT, one at a time since the queue memory has a
//  single read port. Busy stays high until the result, so one command at a time.
//  The result shows in the cycle busy drops, so a new item may be taken then.
//  Reset (rst_n low, synchronous) empties the queue; slot contents are not cleared.
//  No stalls on the result side; busy is the only back-pressure on commands.
module round_robin_run_queue_unit #(
  parameter int QUEUE_DEPTH = rrq_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_WIDTH    = rrq_pkg::ID_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [rrq_pkg::CMD_W-1:0] in_cmd,
  input  logic [rrq_pkg::ENT_W-1:0] in_entity_id,
  output logic                      out_valid,
  output logic                      out_picked_valid,
  output logic [rrq_pkg::ENT_W-1:0] out_picked_id,
  output logic [rrq_pkg::CNT_W-1:0] out_queue_count,
  output logic [rrq_pkg::ST_W-1:0]  out_status
);

  // Queue is circular: a pick just advances the head and copies the old head
  // item to the slot after the tail, which is the same slot when full.
  // Remove scans from the head and then pulls later items down one place.
  rrq_pkg::ctl_t  ctl;
  rrq_pkg::stat_t stat;

  rrq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy)
  );

  rrq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_WIDTH    (ID_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .stat             (stat),
    .in_cmd           (in_cmd),
    .in_entity_id     (in_entity_id),
    .out_valid        (out_valid),
    .out_picked_valid (out_picked_valid),
    .out_picked_id    (out_picked_id),
    .out_queue_count  (out_queue_count),
    .out_status       (out_status)
  );

endmodule

// ===== sv/rrq_ctrl.sv =====
// Sequencer for add, remove (scan and compact) and pick.
module rrq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  rrq_pkg::stat_t stat,
  output rrq_pkg::ctl_t  ctl,
  output logic           busy
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_PICK  = 5'b00100,
    S_SCAN  = 5'b01000,
    S_SHIFT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    ctl             = '0;
    ctl.rd_sel      = rrq_pkg::RD_IDX;
    ctl.wr_sel      = rrq_pkg::WR_TAIL_ID;
    ctl.emit_status = rrq_pkg::ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        unique case (stat.cmd)
          rrq_pkg::CMD_ADD: begin
            ctl.emit = 1'b1;
            if (stat.full) begin
              ctl.emit_status = rrq_pkg::ST_FULL;
            end else begin
              ctl.wr_en   = 1'b1;
              ctl.wr_sel  = rrq_pkg::WR_TAIL_ID;
              ctl.cnt_inc = 1'b1;
            end
          end
          rrq_pkg::CMD_REMOVE: begin
            if (stat.empty) begin
              ctl.emit        = 1'b1;
              ctl.emit_status = rrq_pkg::ST_NOMATCH;
            end else begin
              ctl.rd_en = 1'b1;
              state_nxt = S_SCAN;
            end
          end
          rrq_pkg::CMD_PICK: begin
            if (stat.empty) begin
              ctl.emit = 1'b1;
            end else begin
              ctl.rd_en = 1'b1;
              state_nxt = S_PICK;
            end
          end
          default: begin
            ctl.emit = 1'b1;
          end
        endcase
      end
      S_PICK: begin
        ctl.wr_en     = 1'b1;
        ctl.wr_sel    = rrq_pkg::WR_TAIL_RD;
        ctl.head_inc  = 1'b1;
        ctl.emit      = 1'b1;
        ctl.emit_pick = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_SCAN: begin
        if (stat.match) begin
          if (stat.last) begin
            ctl.cnt_dec = 1'b1;
            ctl.emit    = 1'b1;
            state_nxt   = S_IDLE;
          end else begin
            ctl.rd_en  = 1'b1;
            ctl.rd_sel = rrq_pkg::RD_IDX1;
            state_nxt  = S_SHIFT;
          end
        end else if (stat.last) begin
          ctl.emit        = 1'b1;
          ctl.emit_status = rrq_pkg::ST_NOMATCH;
          state_nxt       = S_IDLE;
        end else begin
          ctl.rd_en   = 1'b1;
          ctl.rd_sel  = rrq_pkg::RD_IDX1;
          ctl.idx_inc = 1'b1;
        end
      end
      S_SHIFT: begin
        // read data holds the entry after the scan index; pull it down
        ctl.wr_en  = 1'b1;
        ctl.wr_sel = rrq_pkg::WR_IDX_RD;
        if (stat.last1) begin
          ctl.cnt_dec = 1'b1;
          ctl.emit    = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          ctl.rd_en   = 1'b1;
          ctl.rd_sel  = rrq_pkg::RD_IDX2;
          ctl.idx_inc = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/rrq_dp.sv =====
// Queue storage (circular), pointers, scan index and result registers.
module rrq_dp #(
  parameter int QUEUE_DEPTH = rrq_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_WIDTH    = rrq_pkg::ID_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rrq_pkg::ctl_t             ctl,
  output rrq_pkg::stat_t            stat,
  input  logic [rrq_pkg::CMD_W-1:0] in_cmd,
  input  logic [rrq_pkg::ENT_W-1:0] in_entity_id,
  output logic                      out_valid,
  output logic                      out_picked_valid,
  output logic [rrq_pkg::ENT_W-1:0] out_picked_id,
  output logic [rrq_pkg::CNT_W-1:0] out_queue_count,
  output logic [rrq_pkg::ST_W-1:0]  out_status
);

  localparam int AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int SW    = CW + 2;
  localparam int ENT_W = rrq_pkg::ENT_W;
  localparam int CNT_W = rrq_pkg::CNT_W;
  localparam int CMD_W = rrq_pkg::CMD_W;
  localparam int ST_W  = rrq_pkg::ST_W;

  logic [ID_WIDTH-1:0] mem [QUEUE_DEPTH];

  logic [AW-1:0]       head_r;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       idx_r;
  logic [CMD_W-1:0]    cmd_r;
  logic [ID_WIDTH-1:0] id_r;
  logic [ID_WIDTH-1:0] rdata_r;

  logic [SW-1:0]       rd_off;
  logic [AW-1:0]       rd_addr, wr_addr;
  logic [ID_WIDTH-1:0] wr_data;
  logic [CW:0]         idx_p1, idx_p2;

  logic                out_valid_r, picked_valid_r;
  logic [ENT_W-1:0]    picked_id_r;
  logic [CNT_W-1:0]    queue_count_r;
  logic [ST_W-1:0]     status_r;

  // logical offset from head to physical slot, wrapping at the depth
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [SW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(head) + off;
    if (sum >= SW'(QUEUE_DEPTH)) begin
      sum = sum - SW'(QUEUE_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  always_comb begin
    case (ctl.rd_sel)
      rrq_pkg::RD_IDX:  rd_off = SW'(idx_r);
      rrq_pkg::RD_IDX1: rd_off = SW'(idx_r) + SW'(1);
      default:          rd_off = SW'(idx_r) + SW'(2);
    endcase
  end

  assign rd_addr = phys(head_r, rd_off);

  always_comb begin
    case (ctl.wr_sel)
      rrq_pkg::WR_TAIL_ID: begin
        wr_addr = phys(head_r, SW'(count_r));
        wr_data = id_r;
      end
      rrq_pkg::WR_TAIL_RD: begin
        wr_addr = phys(head_r, SW'(count_r));
        wr_data = rdata_r;
      end
      default: begin
        wr_addr = phys(head_r, SW'(idx_r));
        wr_data = rdata_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.cnt_inc) begin
      count_nxt = count_r + CW'(1);
    end else if (ctl.cnt_dec) begin
      count_nxt = count_r - CW'(1);
    end
  end

  assign idx_p1 = {1'b0, idx_r} + (CW+1)'(1);
  assign idx_p2 = {1'b0, idx_r} + (CW+1)'(2);

  assign stat.cmd   = cmd_r;
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CW'(QUEUE_DEPTH));
  assign stat.last  = (idx_p1 == {1'b0, count_r});
  assign stat.last1 = (idx_p2 == {1'b0, count_r});
  assign stat.match = (rdata_r == id_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= ctl.emit;
      if (ctl.head_inc) begin
        head_r <= (head_r == AW'(QUEUE_DEPTH - 1)) ? '0 : head_r + AW'(1);
      end
      if (ctl.load) begin
        idx_r <= '0;
      end else if (ctl.idx_inc) begin
        idx_r <= idx_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= in_cmd;
      id_r  <= ID_WIDTH'(in_entity_id);
    end
    if (ctl.emit) begin
      picked_valid_r <= ctl.emit_pick;
      picked_id_r    <= ctl.emit_pick ? ENT_W'(rdata_r) : '0;
      queue_count_r  <= CNT_W'(count_nxt);
      status_r       <= ctl.emit_status;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_picked_valid = picked_valid_r;
  assign out_picked_id    = picked_id_r;
  assign out_queue_count  = queue_count_r;
  assign out_status       = status_r;

endmodule

// ===== sv/rrq_checker.sv =====
// Port-level checks for the run queue, bound to the top level.
`include "round_robin_run_queue_unit_assert.svh"

module rrq_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic                      out_valid,
  input logic                      out_picked_valid,
  input logic [rrq_pkg::ENT_W-1:0] out_picked_id,
  input logic [rrq_pkg::ST_W-1:0]  out_status
);

  `RRQ_ASSERT_SAME(a_result_when_idle, out_valid, !busy)
  `RRQ_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy && !out_valid)
  `RRQ_ASSERT_SAME(a_done_gives_result, $fell(busy) && $past(rst_n), out_valid)
  `RRQ_ASSERT_SAME(a_no_pick_zero_id, out_valid && !out_picked_valid, out_picked_id == '0)
  `RRQ_ASSERT_SAME(a_pick_status_ok, out_valid && out_picked_valid,
                   out_status == rrq_pkg::ST_OK)

endmodule

bind round_robin_run_queue_unit rrq_checker u_rrq_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_picked_valid (out_picked_valid),
  .out_picked_id    (out_picked_id),
  .out_status       (out_status)
);
